// ===== sv/hsdc_pkg.sv =====
// Shared constants, types and helper functions of the hash-set duplicate checker.
package hsdc_pkg;

  localparam int TABLE_DEPTH = 1024;
  // Largest power of two that does not exceed TABLE_DEPTH sets the usable table.
  localparam int ADDR_W      = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int SLOT_DEPTH  = 1 << ADDR_W;
  localparam int ELEM_W      = 32;
  localparam int CNT_W       = 9;
  localparam int EPOCH_W     = 8;
  localparam int ENTRY_W     = EPOCH_W + ELEM_W;

  localparam logic [CNT_W-1:0] COUNT_MAX     = 9'd511;
  localparam logic [CNT_W-1:0] SET_COUNT_RST = 9'd256;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_WRAP,
    ST_IDLE,
    ST_DECIDE,
    ST_PROBE,
    ST_FINISH
  } hsdc_state_t;

  typedef struct packed {
    logic dup;
    logic ovf;
    logic done;
  } hsdc_result_t;

  // A set size of zero behaves as a set of one element.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] set_count);
    eff_count = (set_count == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : set_count;
  endfunction

  // Address mask of the smallest power of two at or above four times the set
  // size, capped at the table depth.
  function automatic logic [ADDR_W-1:0] table_mask(input logic [CNT_W-1:0] set_count);
    logic [CNT_W-1:0]  eff;
    int                lg;
    logic [ADDR_W-1:0] m;
    eff = eff_count(set_count);
    lg  = 0;
    for (int i = 0; i < CNT_W; i++) begin
      if ((32'd1 << i) < {{(32-CNT_W){1'b0}}, eff}) begin
        lg = i + 1;
      end
    end
    lg = lg + 2;
    for (int b = 0; b < ADDR_W; b++) begin
      m[b] = (b < lg);
    end
    table_mask = m;
  endfunction

endpackage

// ===== sv/hsdc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module hsdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/hsdc_probe.sv =====
// Probe engine: epoch-tagged slot table, linear probing and the per-set flags.
module hsdc_probe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hsdc_pkg::ELEM_W-1:0]  in_element,
  input  logic                         in_first,
  input  logic                         in_last,
  input  logic [hsdc_pkg::CNT_W-1:0]   set_count,
  output logic                         res_valid,
  input  logic                         res_ready,
  output hsdc_pkg::hsdc_result_t       res
);

  import hsdc_pkg::*;

  hsdc_state_t         state_r, state_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic                dup_r, dup_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [ELEM_W-1:0]   elem_r, elem_nxt;
  logic                last_r, last_nxt;
  logic [ADDR_W-1:0]   mask_r, mask_nxt;
  logic [CNT_W-1:0]    eff_r, eff_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]   probe_cnt_r, probe_cnt_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ELEM_W-1:0]   slot_val;
  logic [ADDR_W-1:0]   home;

  hsdc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An entry written in an older epoch reads as empty.
  assign slot_val = (ram_rdata[ENTRY_W-1:ELEM_W] == epoch_r) ? ram_rdata[ELEM_W-1:0] : '0;
  assign home     = elem_r[ADDR_W-1:0] & mask_r;
  assign res      = '{dup: dup_r, ovf: ovf_r, done: last_r};

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    clr_addr_nxt  = clr_addr_r;
    dup_nxt       = dup_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    elem_nxt      = elem_r;
    last_nxt      = last_r;
    mask_nxt      = mask_r;
    eff_nxt       = eff_r;
    pos_nxt       = pos_r;
    probe_cnt_nxt = probe_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = pos_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WRAP: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          elem_nxt  = in_element;
          last_nxt  = in_last;
          mask_nxt  = table_mask(set_count);
          eff_nxt   = eff_count(set_count);
          state_nxt = ST_DECIDE;
          if (in_first) begin
            dup_nxt = 1'b0;
            ovf_nxt = 1'b0;
            cnt_nxt = '0;
            // Running out of epoch tags forces a real sweep of the table.
            if (epoch_r == '1) begin
              epoch_nxt    = '0;
              clr_addr_nxt = '0;
              state_nxt    = ST_WRAP;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end
        end
      end
      ST_DECIDE: begin
        if (cnt_r < COUNT_MAX) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (cnt_r >= eff_r) begin
          ovf_nxt   = 1'b1;
          state_nxt = ST_FINISH;
        end else if (!dup_r && (elem_r != '0)) begin
          ram_re        = 1'b1;
          ram_raddr     = home;
          pos_nxt       = home;
          probe_cnt_nxt = '0;
          state_nxt     = ST_PROBE;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_PROBE: begin
        if (slot_val == '0) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = {epoch_r, elem_r};
          state_nxt = ST_FINISH;
        end else if (slot_val == elem_r) begin
          dup_nxt   = 1'b1;
          state_nxt = ST_FINISH;
        end else if (probe_cnt_r == mask_r) begin
          ovf_nxt   = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          pos_nxt       = (pos_r + 1'b1) & mask_r;
          ram_re        = 1'b1;
          ram_raddr     = pos_nxt;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      epoch_r    <= '0;
      clr_addr_r <= '0;
      dup_r      <= 1'b0;
      ovf_r      <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      epoch_r    <= epoch_nxt;
      clr_addr_r <= clr_addr_nxt;
      dup_r      <= dup_nxt;
      ovf_r      <= ovf_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_r      <= elem_nxt;
    last_r      <= last_nxt;
    mask_r      <= mask_nxt;
    eff_r       <= eff_nxt;
    pos_r       <= pos_nxt;
    probe_cnt_r <= probe_cnt_nxt;
  end

endmodule

// ===== sv/hash_set_duplicate_check_core.sv =====
// Top level of the hash-set duplicate checker: configuration register and result register.
//
// Each input request carries one 32-bit element plus first/last-of-set marks and
// yields exactly one result request with the sticky duplicate flag, the sticky
// overflow flag and an echo of the last-of-set mark. The elements live in an
// open-addressed table held in one synchronous RAM; probing is linear with wrap.
// An accepted element passes through the DECIDE state, one PROBE step per slot
// probed (one RAM read per cycle; no slot is probed when no insert is attempted)
// and the FINISH state before its result is registered. The next element is
// accepted only after that, back in the IDLE state.
// One element is in flight at a time.
// A first-of-set request normally clears the table by moving to a new epoch tag.
// Every 256th set the tags run out and the request instead waits for a sweep of
// all 1024 slots. After reset the same sweep runs once before in_ready rises;
// configuration writes are taken at any time.
// The result register lets the engine finish an element while the receiver
// stalls; a second result then waits inside the engine, and no new input
// request is taken until it has moved into the result register.
module hash_set_duplicate_check_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hsdc_pkg::ELEM_W-1:0]  in_element,
  input  logic                         in_first_of_set,
  input  logic                         in_last_of_set,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_duplicate_found,
  output logic                         out_overflow,
  output logic                         out_set_done,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hsdc_pkg::CNT_W-1:0]   cfg_set_count
);

  import hsdc_pkg::*;

  logic [CNT_W-1:0] set_count_r;
  logic             out_valid_r;
  hsdc_result_t     out_res_r;
  hsdc_result_t     res;
  logic             res_valid;
  logic             res_ready;

  // The set size register is always writable; the table size follows it at
  // every accepted element.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_count_r <= SET_COUNT_RST;
    end else if (cfg_valid) begin
      set_count_r <= cfg_set_count;
    end
  end

  hsdc_probe u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_element(in_element),
    .in_first  (in_first_of_set),
    .in_last   (in_last_of_set),
    .set_count (set_count_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The result register accepts a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_duplicate_found = out_res_r.dup;
  assign out_overflow        = out_res_r.ovf;
  assign out_set_done        = out_res_r.done;

endmodule

// ===== dv/hsdc_verdict_checker.sv =====
// Checker that watches the duplicate checker's request channels, predicts each verdict and compares.
module hsdc_verdict_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [hsdc_pkg::ELEM_W-1:0] in_element,
  input  logic                        in_first_of_set,
  input  logic                        in_last_of_set,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_duplicate_found,
  input  logic                        out_overflow,
  input  logic                        out_set_done,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [hsdc_pkg::CNT_W-1:0]  cfg_set_count,
  output int unsigned                 failures,
  output int unsigned                 verdicts_owed
);

  import hsdc_pkg::*;

  localparam logic [CNT_W-1:0] SET_COUNT_AT_RESET = 9'd256;

  logic [ELEM_W-1:0] slots [SLOT_DEPTH];
  logic              dup_seen;
  logic              overflow_seen;
  logic [CNT_W-1:0]  seen_count;
  logic [CNT_W-1:0]  set_count;
  hsdc_result_t      expected_verdicts [$];

  task automatic forget_set();
    for (int i = 0; i < SLOT_DEPTH; i++) begin
      slots[i] = '0;
    end
    dup_seen      = 1'b0;
    overflow_seen = 1'b0;
    seen_count    = '0;
  endtask

  // Linear probe from the home slot; the table span follows the current set size.
  task automatic file_element(input logic [ELEM_W-1:0] element);
    int unsigned want, span, pos;
    bit          resolved;
    want = 4 * ((set_count == '0) ? 1 : int'(set_count));
    span = 1;
    while (span < want) span = span << 1;
    if (span > SLOT_DEPTH) span = SLOT_DEPTH;
    pos      = element & (span - 1);
    resolved = 1'b0;
    for (int n = 0; n < span && !resolved; n++) begin
      if (slots[pos] == '0) begin
        slots[pos] = element;
        resolved   = 1'b1;
      end else if (slots[pos] == element) begin
        dup_seen = 1'b1;
        resolved = 1'b1;
      end else begin
        pos = (pos + 1) & (span - 1);
      end
    end
    if (!resolved) overflow_seen = 1'b1;
  endtask

  task automatic judge_element(input logic [ELEM_W-1:0] element,
                               input logic first_mark, input logic last_mark);
    int unsigned  limit;
    hsdc_result_t verdict;
    if (first_mark) forget_set();
    limit = (set_count == '0) ? 1 : set_count;
    if (seen_count >= limit) begin
      overflow_seen = 1'b1;
    end else if (!dup_seen && element != '0) begin
      file_element(element);
    end
    if (seen_count != '1) seen_count = seen_count + 1'b1;
    verdict.dup  = dup_seen;
    verdict.ovf  = overflow_seen;
    verdict.done = last_mark;
    expected_verdicts.push_back(verdict);
  endtask

  always @(posedge clk) begin : watch
    hsdc_result_t seen;
    hsdc_result_t want;
    if (!rst_n) begin
      forget_set();
      set_count = SET_COUNT_AT_RESET;
      expected_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) set_count = cfg_set_count;
      if (in_valid && in_ready) begin
        judge_element(in_element, in_first_of_set, in_last_of_set);
      end
      if (out_valid && out_ready) begin
        seen.dup  = out_duplicate_found;
        seen.ovf  = out_overflow;
        seen.done = out_set_done;
        if (expected_verdicts.size() == 0) begin
          if (failures < 10) begin
            $display("%0t: result with no request waiting: dup=%0b ovf=%0b done=%0b",
                     $time, seen.dup, seen.ovf, seen.done);
          end
          failures = failures + 1;
        end else begin
          want = expected_verdicts.pop_front();
          if (want != seen) begin
            if (failures < 10) begin
              $write("%0t: verdict mismatch, expected dup=%0b ovf=%0b done=%0b,",
                     $time, want.dup, want.ovf, want.done);
              $display(" got dup=%0b ovf=%0b done=%0b", seen.dup, seen.ovf, seen.done);
            end
            failures = failures + 1;
          end
        end
      end
    end
    verdicts_owed = expected_verdicts.size();
  end

endmodule

// ===== dv/hash_set_duplicate_check_core_test.sv =====
// Test bench top for the hash-set duplicate checker: reset, stimulus, pacing and verdict.
module hash_set_duplicate_check_core_test;
  import hsdc_pkg::*;

  // Planned request count: about 730 that do real work, plus one long set of 520
  // requests whose tail only exercises the saturating element counter.
  localparam int unsigned PLANNED_REQUESTS = 1250;
  // Quiet time after the last result, to catch any stray result request.
  localparam int unsigned SETTLE_CYCLES    = 64;

  logic              clk                 = 1'b0;
  logic              rst_n               = 1'b0;
  logic              in_valid            = 1'b0;
  logic              in_ready;
  logic [ELEM_W-1:0] in_element          = '0;
  logic              in_first_of_set     = 1'b0;
  logic              in_last_of_set      = 1'b0;
  logic              out_valid;
  logic              out_ready           = 1'b0;
  logic              out_duplicate_found;
  logic              out_overflow;
  logic              out_set_done;
  logic              cfg_valid           = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_set_count       = '0;

  int unsigned       tx_idle_pct         = 26;
  int unsigned       rx_idle_pct         = 52;
  int unsigned       requests_sent       = 0;
  int unsigned       failures;
  int unsigned       verdicts_owed;
  // Nonzero elements of the set being built, so later requests can repeat them.
  logic [ELEM_W-1:0] set_members [$];

  always #4 clk = ~clk;

  // The receiver stalls at random; the rate is set by the current pacing stage.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  hash_set_duplicate_check_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_element          (in_element),
    .in_first_of_set     (in_first_of_set),
    .in_last_of_set      (in_last_of_set),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_duplicate_found (out_duplicate_found),
    .out_overflow        (out_overflow),
    .out_set_done        (out_set_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_set_count       (cfg_set_count)
  );

  hsdc_verdict_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_element          (in_element),
    .in_first_of_set     (in_first_of_set),
    .in_last_of_set      (in_last_of_set),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_duplicate_found (out_duplicate_found),
    .out_overflow        (out_overflow),
    .out_set_done        (out_set_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_set_count       (cfg_set_count),
    .failures            (failures),
    .verdicts_owed       (verdicts_owed)
  );

  // Sends one input request. It is entered right after a rising edge and returns at the
  // rising edge where the request was taken, with valid still high. The caller's next
  // action then either drops valid or replaces the payload, never both in one step.
  // Handshake signals are sampled at the falling edge, where they are settled.
  task automatic send_request(input logic [ELEM_W-1:0] element,
                              input logic first_mark, input logic last_mark);
    // Pacing stages: sender lighter than receiver, then the reverse, then no idling.
    if (requests_sent < PLANNED_REQUESTS / 3) begin
      tx_idle_pct = 26;
      rx_idle_pct <= 52;
    end else if (requests_sent < 2 * PLANNED_REQUESTS / 3) begin
      tx_idle_pct = 52;
      rx_idle_pct <= 26;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_element      <= element;
    in_first_of_set <= first_mark;
    in_last_of_set  <= last_mark;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    requests_sent = requests_sent + 1;
  endtask

  // Holds the sender back until every predicted result has come out. Every request
  // yields exactly one result, so an empty prediction store means the block is idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdicts_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Set size writes happen only with the block drained.
  task automatic write_set_count(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_valid     <= 1'b1;
    cfg_set_count <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One randomly shaped set. Sizes stay small so that many sets go by. Elements mix
  // full random values, repeats of earlier members, zeros, corner values and clusters
  // that share a home slot (often at the top of the table, so probes wrap). A few
  // sets drop their first mark and run on from the previous set, and a few marks
  // appear in the wrong place.
  task automatic send_set(input logic [CNT_W-1:0] target_count);
    int unsigned       eff, span, n, hot, pick;
    bit                repeats;
    logic              first_mark, last_mark;
    logic [ELEM_W-1:0] element;
    eff  = (target_count == '0) ? 1 : target_count;
    span = 4;
    while (span < 4 * eff && span < SLOT_DEPTH) span = span << 1;
    if ($urandom_range(0, 1) == 0) begin
      n = $urandom_range(1, 2);
    end else begin
      n = $urandom_range(1, (eff > 16) ? 16 : eff);
    end
    // Now and then run past the set size to raise the overflow flag.
    if (eff <= 16 && $urandom_range(0, 99) < 15) n = eff + $urandom_range(1, 3);
    repeats = ($urandom_range(0, 1) == 1);
    hot     = ($urandom_range(0, 3) == 0) ? span - 2 : $urandom_range(0, span - 1);
    set_members.delete();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        element = '0;
      end else if (repeats && set_members.size() != 0 && pick < 30) begin
        element = set_members[$urandom_range(0, set_members.size() - 1)];
      end else if (pick < 60) begin
        element = ($urandom & ~(span - 1)) | ((hot + $urandom_range(0, 3)) & (span - 1));
      end else if (pick < 66) begin
        case ($urandom_range(0, 3))
          0:       element = 32'hFFFF_FFFF;
          1:       element = 32'h8000_0000;
          2:       element = 32'h0000_0001;
          default: element = 32'h7FFF_FFFF;
        endcase
      end else begin
        element = $urandom;
      end
      if (element != '0) set_members.push_back(element);
      first_mark = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 99) < 3);
      last_mark  = (i == n - 1) ^ ($urandom_range(0, 99) < 3);
      send_request(element, first_mark, last_mark);
    end
  endtask

  initial begin : stimulus
    logic [CNT_W-1:0]  phase_count;
    logic [ELEM_W-1:0] element;
    int unsigned       phase, phase_start;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The set size is still at its reset value (256, a 1024-slot table)
    // and the table starts empty, so a set can begin without a first mark.
    // A zero element is counted but never stored.
    send_request(32'h0000_0000, 1'b0, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b0, 1'b0);
    // Same home slot as the all-ones element, at the top of the table: the probe wraps.
    send_request(32'h7FFF_FFFF, 1'b0, 1'b0);
    // A repeat raises the duplicate flag.
    send_request(32'hFFFF_FFFF, 1'b0, 1'b1);
    // After a duplicate the element is counted but no longer stored.
    send_request(32'h0000_0001, 1'b0, 1'b0);

    // Set of one: the second element overflows.
    write_set_count(9'd1);
    send_request(32'h8000_0000, 1'b1, 1'b0);
    send_request(32'h0000_0005, 1'b0, 1'b1);

    // A set size of zero behaves as one; zeros still count toward overflow.
    write_set_count(9'd0);
    send_request(32'h0000_0000, 1'b1, 1'b0);
    send_request(32'h0000_0000, 1'b0, 1'b1);

    // Sixteen-slot table: a chain that wraps from the last slot, then a repeat in it.
    write_set_count(9'd4);
    send_request(32'h0000_000F, 1'b1, 1'b0);
    send_request(32'h0000_001F, 1'b0, 1'b0);
    send_request(32'h0000_002F, 1'b0, 1'b0);
    send_request(32'h0000_001F, 1'b0, 1'b1);

    // Growing the table in the middle of a set moves the home slots, so earlier
    // elements are not found again and no duplicate is seen.
    write_set_count(9'd2);
    send_request(32'h0000_0009, 1'b1, 1'b0);
    send_request(32'h0000_0011, 1'b0, 1'b0);
    write_set_count(9'd16);
    send_request(32'h0000_0011, 1'b0, 1'b0);
    send_request(32'h0000_0009, 1'b0, 1'b1);

    // Largest set size, table capped at its depth. A last mark clears nothing, so an
    // element that follows it without a first mark still finds the earlier one.
    write_set_count(9'd511);
    send_request(32'h1234_5678, 1'b1, 1'b0);
    send_request(32'h0000_0000, 1'b0, 1'b1);
    send_request(32'h1234_5678, 1'b0, 1'b0);
    send_request(32'hA5A5_A5A5, 1'b1, 1'b1);

    // A long run of one-element sets uses up the clearing tags, so the table is
    // swept at least once in the middle of traffic.
    write_set_count(9'd1);
    for (int i = 0; i < 260; i++) begin
      send_request($urandom, 1'b1, 1'b1);
    end

    // Random part, in phases of one set size each. Two phases are special: a big set
    // at the largest size, and a set longer than the element counter can hold.
    phase = 0;
    while (requests_sent < PLANNED_REQUESTS) begin
      if (phase == 5) begin
        // Heavily loaded capped table; the tail repeats members to find them deep
        // in the probe chains.
        write_set_count(9'd511);
        set_members.delete();
        for (int i = 0; i < 150; i++) begin
          if (i >= 140) begin
            element = set_members[$urandom_range(0, set_members.size() - 1)];
          end else if ($urandom_range(0, 49) == 0) begin
            element = '0;
          end else begin
            element = $urandom;
            set_members.push_back(element);
          end
          send_request(element, i == 0, i == 149);
        end
      end else if (phase == 10) begin
        // The element count must saturate, not wrap: if it wrapped, a repeat after
        // the 512th element would be probed again and report a duplicate.
        write_set_count(9'd2);
        set_members.delete();
        for (int i = 0; i < 520; i++) begin
          if (i < 2) begin
            element = $urandom | 32'h1;
            set_members.push_back(element);
          end else if ($urandom_range(0, 3) == 0) begin
            element = $urandom;
          end else begin
            element = set_members[$urandom_range(0, 1)];
          end
          send_request(element, i == 0, i == 519);
        end
      end else begin
        case (phase)
          0:       phase_count = 9'd4;
          1:       phase_count = 9'd1;
          2:       phase_count = 9'd0;
          3:       phase_count = 9'd16;
          4:       phase_count = 9'd3;
          6:       phase_count = 9'd7;
          7:       phase_count = 9'd256;
          8:       phase_count = 9'd2;
          9:       phase_count = 9'd64;
          11:      phase_count = 9'd257;
          12:      phase_count = 9'd12;
          13:      phase_count = 9'd31;
          14:      phase_count = 9'd255;
          default: begin
            if ($urandom_range(0, 4) == 0) begin
              phase_count = $urandom_range(0, 511);
            end else begin
              phase_count = $urandom_range(0, 40);
            end
          end
        endcase
        write_set_count(phase_count);
        phase_start = requests_sent;
        while (requests_sent - phase_start < 30 && requests_sent < PLANNED_REQUESTS) begin
          send_set(phase_count);
        end
      end
      phase = phase + 1;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && verdicts_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run, including full-length probes and
  // the table sweeps after reset and when the clearing tag wraps.
  initial begin : watchdog
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
